### src/sic_pkg.sv
package sic_pkg;

    // Access kinds carried by the command channel.
    localparam logic [2:0] KIND_WR_CONTROL = 3'd0;
    localparam logic [2:0] KIND_WR_COMPARE = 3'd1;
    localparam logic [2:0] KIND_TICK       = 3'd2;
    localparam logic [2:0] KIND_RD_LINE    = 3'd3;
    localparam logic [2:0] KIND_RD_CTRL_A  = 3'd4;
    localparam logic [2:0] KIND_RD_CTRL_B  = 3'd5;

    // Configuration register indexes.
    localparam logic [1:0] CFG_LINES_PER_FRAME = 2'd0;
    localparam logic [1:0] CFG_SPECIAL_MODE    = 2'd1;
    localparam logic [1:0] CFG_IRQ_VECTOR      = 2'd2;

    localparam int CFG_DATA_W = 9;

    // Control byte bits.
    localparam int CTL_MASK_BIT    = 0;
    localparam int CTL_COMPARE_BIT = 3;
    localparam int CTL_SPECIAL_BIT = 4;

    // Reset values and limits.
    localparam logic [8:0] LINES_RESET   = 9'd256;
    localparam logic [5:0] ROTARY_RESET  = 6'd32;
    localparam logic [5:0] ROTARY_MAX    = 6'd63;
    localparam logic [7:0] SPECIAL_DELAY = 8'd7;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
        logic [7:0] port_a;
        logic [7:0] port_b;
    } item_t;

    typedef struct packed {
        logic       irq;
        logic [7:0] vector;
        logic [7:0] read_data;
    } result_t;

    typedef struct packed {
        logic [8:0] lines_per_frame;
        logic       special_mode;
        logic [7:0] irq_vector;
    } cfg_t;

    // One frame-wrap step of a rotary counter: down first, then up.
    function automatic logic [5:0] step_rotary(input logic [5:0] count, input logic [7:0] port);
        logic [5:0] c;
        c = count;
        if (port[1] && (c != 6'd0))
        begin
            c = c - 6'd1;
        end
        if (port[0] && (c != ROTARY_MAX))
        begin
            c = c + 6'd1;
        end
        return c;
    endfunction

    function automatic logic [5:0] to_gray(input logic [5:0] n);
        return n ^ (n >> 1);
    endfunction

endpackage

### src/sic_cmd_if.sv
interface sic_cmd_if;
    logic       valid;
    logic       ready;
    logic [2:0] kind;
    logic [7:0] data;
    logic [7:0] port_a;
    logic [7:0] port_b;

    modport source (output valid, output kind, output data, output port_a, output port_b,
                    input ready);
    modport sink   (input valid, input kind, input data, input port_a, input port_b,
                    output ready);
endinterface

### src/sic_rsp_if.sv
interface sic_rsp_if;
    logic       valid;
    logic       ready;
    logic       irq;
    logic [7:0] vector;
    logic [7:0] read_data;

    modport source (output valid, output irq, output vector, output read_data, input ready);
    modport sink   (input valid, input irq, input vector, input read_data, output ready);
endinterface

### src/sic_core.sv
module sic_core (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  sic_pkg::item_t   item,
    input  sic_pkg::cfg_t    cfg,
    output sic_pkg::result_t result
);

    logic [7:0] line_now_reg,     line_now_next;
    logic [7:0] line_compare_reg, line_compare_next;
    logic [7:0] control_reg,      control_next;
    logic [7:0] special_line_reg, special_line_next;
    logic [5:0] rotary_a_reg,     rotary_a_next;
    logic [5:0] rotary_b_reg,     rotary_b_next;

    logic [8:0] line_inc;
    logic [7:0] delay_line;
    logic       fire;
    logic [7:0] fire_vector;

    // Next state and result for the item held in the input register.
    always_comb
    begin
        line_now_next     = line_now_reg;
        line_compare_next = line_compare_reg;
        control_next      = control_reg;
        special_line_next = special_line_reg;
        rotary_a_next     = rotary_a_reg;
        rotary_b_next     = rotary_b_reg;
        line_inc          = {1'b0, line_now_reg} + 9'd1;
        delay_line        = line_now_reg + sic_pkg::SPECIAL_DELAY;
        fire              = 1'b0;
        fire_vector       = 8'd0;
        result            = '0;

        case (item.kind)
            sic_pkg::KIND_WR_CONTROL:
            begin
                control_next = item.data;
                // Arm the delayed interrupt, pulled in ahead of a compare line in the window.
                if (item.data[sic_pkg::CTL_SPECIAL_BIT])
                begin
                    if ((line_compare_reg > line_now_reg) && (line_compare_reg < delay_line))
                    begin
                        special_line_next = line_compare_reg - 8'd1;
                    end
                    else
                    begin
                        special_line_next = delay_line;
                    end
                end
            end
            sic_pkg::KIND_WR_COMPARE:
            begin
                line_compare_next = item.data;
            end
            sic_pkg::KIND_TICK:
            begin
                // Advance the line; a normal-mode frame wrap steps the rotary counters.
                if (!cfg.special_mode && (line_inc == cfg.lines_per_frame))
                begin
                    line_now_next = 8'd0;
                    rotary_a_next = sic_pkg::step_rotary(rotary_a_reg, item.port_a);
                    rotary_b_next = sic_pkg::step_rotary(rotary_b_reg, item.port_b);
                end
                else
                begin
                    line_now_next = line_inc[7:0];
                end
                if (control_reg[sic_pkg::CTL_COMPARE_BIT] && (line_now_next == line_compare_reg))
                begin
                    fire        = 1'b1;
                    fire_vector = cfg.irq_vector;
                end
                // The special interrupt wins when both match.
                if (cfg.special_mode && control_reg[sic_pkg::CTL_SPECIAL_BIT]
                    && (line_now_next == special_line_reg))
                begin
                    fire        = 1'b1;
                    fire_vector = {cfg.irq_vector[7:4], 4'h0};
                end
                if (fire && !control_reg[sic_pkg::CTL_MASK_BIT])
                begin
                    result.irq    = 1'b1;
                    result.vector = fire_vector;
                end
            end
            sic_pkg::KIND_RD_LINE:
            begin
                result.read_data = line_now_reg;
            end
            sic_pkg::KIND_RD_CTRL_A:
            begin
                result.read_data = {item.port_a[7:6], sic_pkg::to_gray(rotary_a_reg)};
            end
            sic_pkg::KIND_RD_CTRL_B:
            begin
                result.read_data = {item.port_b[7], 1'b0, sic_pkg::to_gray(rotary_b_reg)};
            end
            default:
            begin
                result = '0;
            end
        endcase
    end

    // State registers update when the item moves into the result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_now_reg     <= 8'd0;
            line_compare_reg <= 8'd0;
            control_reg      <= 8'd0;
            special_line_reg <= 8'd0;
            rotary_a_reg     <= sic_pkg::ROTARY_RESET;
            rotary_b_reg     <= sic_pkg::ROTARY_RESET;
        end
        else if (step)
        begin
            line_now_reg     <= line_now_next;
            line_compare_reg <= line_compare_next;
            control_reg      <= control_next;
            special_line_reg <= special_line_next;
            rotary_a_reg     <= rotary_a_next;
            rotary_b_reg     <= rotary_b_next;
        end
    end

endmodule

### src/scanline_interrupt_controller_top.sv
// Scanline interrupt controller with rotary controller tracking.
// The cmd channel carries one bus access or one scanline tick per transfer:
// control and compare line writes, ticks, line reads and controller reads.
// The rsp channel returns exactly one result per command, in order: the
// interrupt flag and vector for a tick, the read byte for a read kind.
// Configuration (frame length, special mode, vector byte) is written through
// cfg_we / cfg_index / cfg_wdata while no command is in flight.
// A transferred command lands in the input register, and when it advances its
// result is loaded into the output register, valid from then on. Throughput
// is one command per cycle while the receiver takes results; the per-item work
// is one increment and a few 8-bit compares between those two registers.
// When the receiver stalls, the output register holds its result and the
// input register holds one more command; cmd.ready drops only when both are
// full, and comes back in the same cycle the result is taken.
// Reset clears the line, compare, control and delay registers, sets both
// rotary counters to 32, the frame length to 256, special mode off and the
// vector to zero, and empties both pipeline registers.
module scanline_interrupt_controller_top (
    input  logic                              clk,
    input  logic                              rst_n,
    sic_cmd_if.sink                           cmd,
    sic_rsp_if.source                         rsp,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [sic_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

    sic_pkg::cfg_t    cfg_reg;
    sic_pkg::item_t   item_reg;
    logic             item_valid_reg;
    sic_pkg::result_t result_reg;
    logic             result_valid_reg;
    sic_pkg::result_t result_next;
    logic             advance;

    // Configuration writes; an unknown index is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lines_per_frame <= sic_pkg::LINES_RESET;
            cfg_reg.special_mode    <= 1'b0;
            cfg_reg.irq_vector      <= 8'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                sic_pkg::CFG_LINES_PER_FRAME: cfg_reg.lines_per_frame <= cfg_wdata;
                sic_pkg::CFG_SPECIAL_MODE:    cfg_reg.special_mode    <= cfg_wdata[0];
                sic_pkg::CFG_IRQ_VECTOR:      cfg_reg.irq_vector      <= cfg_wdata[7:0];
                default:                      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    // The held command moves on whenever the output register is free or drains.
    assign advance   = item_valid_reg && (!result_valid_reg || rsp.ready);
    assign cmd.ready = !item_valid_reg || advance;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else if (cmd.ready)
        begin
            item_valid_reg <= cmd.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.valid && cmd.ready)
        begin
            item_reg.kind   <= cmd.kind;
            item_reg.data   <= cmd.data;
            item_reg.port_a <= cmd.port_a;
            item_reg.port_b <= cmd.port_b;
        end
    end

    sic_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (advance),
        .item   (item_reg),
        .cfg    (cfg_reg),
        .result (result_next)
    );

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            result_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            result_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign rsp.valid     = result_valid_reg;
    assign rsp.irq       = result_reg.irq;
    assign rsp.vector    = result_reg.vector;
    assign rsp.read_data = result_reg.read_data;

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam int DRAIN_CYCLES = 6;
    localparam int HOLD_CYCLES  = 80;
    localparam int PHASE_ITEMS  = 90;

    // Access kinds the block decodes as no-ops, and the unused register slot.
    localparam logic [2:0] KIND_SPARE_6    = 3'd6;
    localparam logic [2:0] KIND_SPARE_7    = 3'd7;
    localparam logic [1:0] CFG_SPARE_INDEX = 2'd3;

    // Control byte masks.
    localparam logic [7:0] CTL_MASK    = 8'h01 << sic_pkg::CTL_MASK_BIT;
    localparam logic [7:0] CTL_COMPARE = 8'h01 << sic_pkg::CTL_COMPARE_BIT;
    localparam logic [7:0] CTL_SPECIAL = 8'h01 << sic_pkg::CTL_SPECIAL_BIT;

    // Vector and controller read masks.
    localparam logic [7:0] VECTOR_HIGH_NIBBLE = 8'hF0;
    localparam logic [7:0] CTRL_A_BUTTONS     = 8'hC0;
    localparam logic [7:0] CTRL_B_BUTTON      = 8'h80;

    // Turn bits of an input port.
    localparam logic [1:0] TURN_UP   = 2'b01;
    localparam logic [1:0] TURN_DOWN = 2'b10;
    localparam logic [1:0] TURN_BOTH = 2'b11;

    logic                           clk = 1'b0;
    logic                           rst_n;
    logic                           cfg_we;
    logic [1:0]                     cfg_index;
    logic [sic_pkg::CFG_DATA_W-1:0] cfg_wdata;

    sic_cmd_if cmd_ch();
    sic_rsp_if rsp_ch();

    scanline_interrupt_controller_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predicted register settings.
    logic [8:0] cfg_lines   = sic_pkg::LINES_RESET;
    logic       cfg_special = 1'b0;
    logic [7:0] cfg_vector  = 8'h00;

    // Predicted internal state.
    logic [7:0] cur_line   = 8'h00;
    logic [7:0] cmp_line   = 8'h00;
    logic [7:0] ctl_byte   = 8'h00;
    logic [7:0] delay_line = 8'h00;
    logic [5:0] dial_a     = sic_pkg::ROTARY_RESET;
    logic [5:0] dial_b     = sic_pkg::ROTARY_RESET;

    sic_pkg::result_t expected_results[$];
    int               mismatch_count = 0;

    // Traffic shaping knobs.
    int         send_idle_pct = 0;
    int         rsp_stall_pct = 0;
    logic       hold_start    = 1'b0;
    int         hold_left     = 0;
    bit         turn_biased   = 1'b0;
    logic [1:0] turn_bias_a   = TURN_UP;
    logic [1:0] turn_bias_b   = TURN_DOWN;

    // Clock generation.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Saturating dial step at a frame wrap: the down turn is applied before the up turn.
    function automatic logic [5:0] dial_after_wrap(input logic [5:0] count,
                                                   input logic [7:0] port);
        logic [5:0] c;
        c = count;
        if (port[1] && (c > 6'd0))
            c = c - 6'd1;
        if (port[0] && (c < sic_pkg::ROTARY_MAX))
            c = c + 6'd1;
        return c;
    endfunction

    function automatic logic [5:0] gray6(input logic [5:0] n);
        return n ^ {1'b0, n[5:1]};
    endfunction

    // Updates the predicted state for one access and returns the result it should produce.
    function automatic sic_pkg::result_t predict_access(input sic_pkg::item_t it);
        sic_pkg::result_t r;
        logic [8:0]       next_line;
        logic [7:0]       window_end;
        logic             fire;
        logic [7:0]       vec;
        r    = '0;
        fire = 1'b0;
        vec  = 8'h00;
        case (it.kind)
            sic_pkg::KIND_WR_CONTROL:
            begin
                ctl_byte = it.data;
                // The delayed line is armed a few lines ahead, or just before a nearer compare line.
                if (it.data[sic_pkg::CTL_SPECIAL_BIT])
                begin
                    window_end = cur_line + sic_pkg::SPECIAL_DELAY;
                    if ((cmp_line > cur_line) && (cmp_line < window_end))
                        window_end = cmp_line - 8'd1;
                    delay_line = window_end;
                end
            end
            sic_pkg::KIND_WR_COMPARE:
                cmp_line = it.data;
            sic_pkg::KIND_TICK:
            begin
                next_line = {1'b0, cur_line} + 9'd1;
                if (!cfg_special && (next_line == cfg_lines))
                begin
                    cur_line = 8'h00;
                    dial_a   = dial_after_wrap(dial_a, it.port_a);
                    dial_b   = dial_after_wrap(dial_b, it.port_b);
                end
                else
                begin
                    cur_line = next_line[7:0];
                end
                if (ctl_byte[sic_pkg::CTL_COMPARE_BIT] && (cur_line == cmp_line))
                begin
                    fire = 1'b1;
                    vec  = cfg_vector;
                end
                // The delayed interrupt takes priority when both fire on one tick.
                if (cfg_special && ctl_byte[sic_pkg::CTL_SPECIAL_BIT] && (cur_line == delay_line))
                begin
                    fire = 1'b1;
                    vec  = cfg_vector & VECTOR_HIGH_NIBBLE;
                end
                if (fire && !ctl_byte[sic_pkg::CTL_MASK_BIT])
                begin
                    r.irq    = 1'b1;
                    r.vector = vec;
                end
            end
            sic_pkg::KIND_RD_LINE:
                r.read_data = cur_line;
            sic_pkg::KIND_RD_CTRL_A:
                r.read_data = (it.port_a & CTRL_A_BUTTONS) | {2'b00, gray6(dial_a)};
            sic_pkg::KIND_RD_CTRL_B:
                r.read_data = (it.port_b & CTRL_B_BUTTON) | {2'b00, gray6(dial_b)};
            default:
                r = '0;
        endcase
        return r;
    endfunction

    function automatic sic_pkg::item_t make_item(input logic [2:0] kind,
                                                 input logic [7:0] data,
                                                 input logic [7:0] pa, input logic [7:0] pb);
        sic_pkg::item_t it;
        it.kind   = kind;
        it.data   = data;
        it.port_a = pa;
        it.port_b = pb;
        return it;
    endfunction

    // Random access, weighted toward ticks and toward compare lines close to the current line.
    function automatic sic_pkg::item_t random_access();
        sic_pkg::item_t it;
        int             pick;
        it.data   = 8'($urandom_range(255));
        it.port_a = 8'($urandom_range(255));
        it.port_b = 8'($urandom_range(255));
        if (turn_biased && ($urandom_range(99) < 60))
            it.port_a[1:0] = turn_bias_a;
        if (turn_biased && ($urandom_range(99) < 60))
            it.port_b[1:0] = turn_bias_b;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            it.kind = sic_pkg::KIND_TICK;
        end
        else if (pick < 62)
        begin
            it.kind = sic_pkg::KIND_WR_CONTROL;
            if ($urandom_range(3) != 0)
                it.data[sic_pkg::CTL_MASK_BIT] = 1'b0;
            if ($urandom_range(9) < 7)
                it.data[sic_pkg::CTL_COMPARE_BIT] = 1'b1;
        end
        else if (pick < 72)
        begin
            it.kind = sic_pkg::KIND_WR_COMPARE;
            if ($urandom_range(1) != 0)
                it.data = cur_line + 8'($urandom_range(10));
        end
        else if (pick < 80)
        begin
            it.kind = sic_pkg::KIND_RD_LINE;
        end
        else if (pick < 88)
        begin
            it.kind = sic_pkg::KIND_RD_CTRL_A;
        end
        else if (pick < 96)
        begin
            it.kind = sic_pkg::KIND_RD_CTRL_B;
        end
        else
        begin
            it.kind = ($urandom_range(1) != 0) ? KIND_SPARE_6 : KIND_SPARE_7;
        end
        return it;
    endfunction

    // Offers one access, with random idle cycles first, and records its expected result
    // once the transfer happens. Valid is left high for a following access.
    task automatic send_item(input sic_pkg::item_t it);
        while ($urandom_range(99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
        end
        cmd_ch.valid  <= 1'b1;
        cmd_ch.kind   <= it.kind;
        cmd_ch.data   <= it.data;
        cmd_ch.port_a <= it.port_a;
        cmd_ch.port_b <= it.port_b;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        expected_results.push_back(predict_access(it));
    endtask

    // Stops offering and waits until every expected result has been taken.
    task automatic settle();
        cmd_ch.valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [8:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= value;
        @(posedge clk);
        case (index)
            sic_pkg::CFG_LINES_PER_FRAME: cfg_lines   = value;
            sic_pkg::CFG_SPECIAL_MODE:    cfg_special = value[0];
            sic_pkg::CFG_IRQ_VECTOR:      cfg_vector  = value[7:0];
            default:                      ;
        endcase
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Writes all three registers; unused upper data bits carry random values.
    task automatic configure(input logic [8:0] lines, input logic special,
                             input logic [7:0] vec);
        logic [7:0] junk;
        junk = 8'($urandom_range(255));
        write_reg(sic_pkg::CFG_LINES_PER_FRAME, lines);
        write_reg(sic_pkg::CFG_SPECIAL_MODE, {junk, special});
        write_reg(sic_pkg::CFG_IRQ_VECTOR, {junk[0], vec});
    endtask

    // Brings the line back to zero with one tick, by ending the frame right after it.
    task automatic rewind_frame();
        if (cur_line != 8'h00)
        begin
            write_reg(sic_pkg::CFG_SPECIAL_MODE, 9'd0);
            write_reg(sic_pkg::CFG_LINES_PER_FRAME, {1'b0, cur_line} + 9'd1);
            send_item(make_item(sic_pkg::KIND_TICK, 8'($urandom_range(255)),
                                8'($urandom_range(255)), 8'($urandom_range(255))));
            settle();
        end
    endtask

    task automatic run_phase(input logic [8:0] lines, input logic special,
                             input logic [7:0] vec, input int idle_pct, input int stall_pct,
                             input bit biased, input logic [1:0] bias_a,
                             input logic [1:0] bias_b, input int count);
        settle();
        if (!special && (lines inside {[9'd1:9'd40]}))
            rewind_frame();
        configure(lines, special, vec);
        send_idle_pct = idle_pct;
        rsp_stall_pct = stall_pct;
        turn_biased   = biased;
        turn_bias_a   = bias_a;
        turn_bias_b   = bias_b;
        repeat (count) send_item(random_access());
    endtask

    // Compares one transfer on the result channel with the oldest expectation.
    task automatic check_result();
        sic_pkg::result_t want;
        if (expected_results.size() == 0)
        begin
            $display("%0t: unexpected result irq=%0d vector=%02h read_data=%02h",
                     $time, rsp_ch.irq, rsp_ch.vector, rsp_ch.read_data);
            mismatch_count++;
        end
        else
        begin
            want = expected_results.pop_front();
            if (rsp_ch.irq !== want.irq)
            begin
                $display("%0t: irq mismatch, expected %0d, actual %0d",
                         $time, want.irq, rsp_ch.irq);
                mismatch_count++;
            end
            if (rsp_ch.vector !== want.vector)
            begin
                $display("%0t: vector mismatch, expected %02h, actual %02h",
                         $time, want.vector, rsp_ch.vector);
                mismatch_count++;
            end
            if (rsp_ch.read_data !== want.read_data)
            begin
                $display("%0t: read_data mismatch, expected %02h, actual %02h",
                         $time, want.read_data, rsp_ch.read_data);
                mismatch_count++;
            end
        end
    endtask

    // Result side: check each transfer and pick the next ready value.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            check_result();
        rsp_ch.ready <= (hold_left == 0) && ($urandom_range(99) >= rsp_stall_pct);
    end

    // Long receiver hold-off, counted in cycles.
    always @(posedge clk)
    begin
        if (hold_start)
            hold_left <= HOLD_CYCLES;
        else if (hold_left != 0)
            hold_left <= hold_left - 1;
    end

    // Frame wraps with a one-line frame step the dials, including both turn bits at once.
    task automatic test_rotary_wrap();
        configure(9'd1, 1'b0, 8'h00);
        write_reg(CFG_SPARE_INDEX, 9'h1FF);
        send_item(make_item(sic_pkg::KIND_TICK, 8'h00, {6'h00, TURN_BOTH}, {6'h00, TURN_UP}));
        send_item(make_item(sic_pkg::KIND_TICK, 8'hFF, {6'h3F, TURN_DOWN},
                            {6'h3F, TURN_DOWN}));
        send_item(make_item(sic_pkg::KIND_RD_CTRL_A, 8'h00, 8'hFF, 8'h00));
        send_item(make_item(sic_pkg::KIND_RD_CTRL_B, 8'h00, 8'h00, 8'hFF));
    endtask

    // Reads with buttons released, and the two kinds the block ignores.
    task automatic test_reads();
        send_item(make_item(sic_pkg::KIND_RD_CTRL_A, 8'hFF, 8'h00, 8'hFF));
        send_item(make_item(sic_pkg::KIND_RD_CTRL_B, 8'hFF, 8'hFF, 8'h00));
        send_item(make_item(sic_pkg::KIND_RD_LINE, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(KIND_SPARE_6, 8'hFF, 8'hFF, 8'hFF));
        send_item(make_item(KIND_SPARE_7, 8'hFF, 8'hFF, 8'hFF));
    endtask

    // Compare line interrupt, then the same interrupt with the mask bit set.
    task automatic test_compare_irq();
        settle();
        configure(sic_pkg::LINES_RESET, 1'b0, 8'hFF);
        send_item(make_item(sic_pkg::KIND_WR_COMPARE, cur_line + 8'd2, 8'h00, 8'h00));
        send_item(make_item(sic_pkg::KIND_WR_CONTROL, CTL_COMPARE, 8'h00, 8'h00));
        send_item(make_item(sic_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00));
        send_item(make_item(sic_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00));
        send_item(make_item(sic_pkg::KIND_WR_CONTROL, CTL_COMPARE | CTL_MASK, 8'h00, 8'h00));
        send_item(make_item(sic_pkg::KIND_WR_COMPARE, cur_line + 8'd1, 8'h00, 8'h00));
        send_item(make_item(sic_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00));
    endtask

    // Special mode: the delayed line and the compare line coincide, so both fire together.
    task automatic test_special_irq();
        settle();
        configure(sic_pkg::LINES_RESET, 1'b1, 8'hA7);
        send_item(make_item(sic_pkg::KIND_WR_COMPARE, cur_line + sic_pkg::SPECIAL_DELAY,
                            8'h00, 8'h00));
        send_item(make_item(sic_pkg::KIND_WR_CONTROL, CTL_COMPARE | CTL_SPECIAL, 8'h00, 8'h00));
        repeat (7) send_item(make_item(sic_pkg::KIND_TICK, 8'h00, 8'h00, 8'h00));
    endtask

    // Random traffic over several register settings and idle patterns.
    task automatic test_random_traffic();
        run_phase(sic_pkg::LINES_RESET, 1'b0, 8'h00, 0, 0, 1'b0, TURN_UP, TURN_UP,
                  PHASE_ITEMS);
        run_phase(9'd1, 1'b0, 8'hFF, 63, 0, 1'b1, TURN_UP, TURN_DOWN, PHASE_ITEMS);
        run_phase(9'd7, 1'b0, 8'($urandom_range(255)), 0, 63, 1'b1, TURN_DOWN, TURN_UP,
                  PHASE_ITEMS);
        run_phase(9'd0, 1'b0, 8'($urandom_range(255)), 24, 24, 1'b0, TURN_UP, TURN_UP,
                  PHASE_ITEMS);
        run_phase(sic_pkg::LINES_RESET, 1'b1, 8'($urandom_range(255)), 0, 0, 1'b0,
                  TURN_UP, TURN_UP, PHASE_ITEMS);
        run_phase(9'h1FF, 1'b0, 8'($urandom_range(255)), 63, 0, 1'b0, TURN_UP, TURN_UP,
                  PHASE_ITEMS);
        // Long enough to run past the end of a full 256-line frame.
        run_phase(sic_pkg::LINES_RESET, 1'b0, 8'hFF, 0, 63, 1'b0, TURN_UP, TURN_UP,
                  2 * (256 - int'(cur_line)) + 40);
        run_phase(9'($urandom_range(2, 256)), 1'b1, 8'($urandom_range(255)), 24, 24, 1'b0,
                  TURN_UP, TURN_UP, PHASE_ITEMS);
        run_phase(9'($urandom_range(1, 40)), 1'b0, 8'($urandom_range(255)), 24, 24, 1'b1,
                  TURN_UP, TURN_UP, PHASE_ITEMS);
    endtask

    // The receiver holds off while accesses keep coming, so the input side stalls.
    task automatic test_backpressure();
        settle();
        send_idle_pct = 0;
        rsp_stall_pct = 0;
        turn_biased   = 1'b0;
        hold_start <= 1'b1;
        @(posedge clk);
        hold_start <= 1'b0;
        repeat (40) send_item(random_access());
    endtask

    initial
    begin
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= sic_pkg::CFG_LINES_PER_FRAME;
        cfg_wdata     <= '0;
        cmd_ch.valid  <= 1'b0;
        cmd_ch.kind   <= sic_pkg::KIND_RD_LINE;
        cmd_ch.data   <= 8'h00;
        cmd_ch.port_a <= 8'h00;
        cmd_ch.port_b <= 8'h00;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_rotary_wrap();
        test_reads();
        test_compare_irq();
        test_special_irq();
        test_random_traffic();
        test_backpressure();
        settle();

        if (mismatch_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial
    begin
        #2_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### sim.f
src/sic_pkg.sv
src/sic_cmd_if.sv
src/sic_rsp_if.sv
src/sic_core.sv
src/scanline_interrupt_controller_top.sv
sim/tb_top.sv
